FILE: hdl/mtbc_pkg.sv
// Shared types and constants of the multi-target blink controller.
// Holds the item payloads, the table entry word and the controller links.
// No dependencies.
`timescale 1ns / 1ps

package mtbc_pkg;

    localparam int TGT_W      = 4;
    localparam int CNT_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Operation codes of an input item.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_INPUT  = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_EN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_BLINKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BLINKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BLINKS   = 3'd4;

    // Bit positions within the entry flags.
    localparam int FL_CURSOR = 0;
    localparam int FL_TEXT   = 1;
    localparam int FL_UPDATE = 2;

    typedef struct packed {
        logic [1:0]       op;
        logic [TGT_W-1:0] target;
        logic             is_viewport;
        logic             is_primary;
        logic             is_focused;
        logic             blink_seen;
        logic             is_active;
    } t_in_item;

    typedef struct packed {
        logic [TGT_W-1:0] out_target;
        logic             target_valid;
        logic             cursor_on;
        logic             text_on;
        logic             update_on;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] skip_left;
        logic [CNT_W-1:0] cursor_left;
        logic [CNT_W-1:0] text_left;
        logic [2:0]       flags;
    } t_entry;

    typedef struct packed {
        logic rd_in;       // read the table at the incoming item's target
        logic capture;     // input transfer accepted
        logic scan_step;   // advance the walk index
        logic exec_upd;    // apply a set-effect or input-received item
        logic exec_walk;   // apply one tick step to the current entry
        logic finish;      // close a tick
    } t_ctl_cmd;

    typedef struct packed {
        logic in_tick;
        logic in_upd;
        logic running;
        logic idx_valid;
        logic rest_empty;
        logic is_last;
        logic emitted;
        logic out_free;
    } t_ctl_sts;

endpackage

FILE: hdl/mtbc_in_if.sv
// Input channel of the blink controller: valid, ready and one input item.
// Depends on mtbc_pkg.
`timescale 1ns / 1ps

interface mtbc_in_if import mtbc_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mtbc_out_if.sv
// Result channel of the blink controller: valid, ready and one result item.
// Depends on mtbc_pkg.
`timescale 1ns / 1ps

interface mtbc_out_if import mtbc_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mtbc_ctl.sv
// Sequencing state machine of the blink controller.
// Depends on mtbc_pkg; drives the datapath through t_ctl_cmd.
`timescale 1ns / 1ps

module mtbc_ctl import mtbc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_SCAN = 5'b00100,
        S_WALK = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.rd_in = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.in_tick) begin
                        n_state = i_sts.running ? S_SCAN : S_FIN;
                    end else if (i_sts.in_upd) begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                if (i_sts.out_free) begin
                    o_cmd.exec_upd = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.rest_empty) begin
                    n_state = S_FIN;
                end else if (i_sts.idx_valid) begin
                    n_state = S_WALK;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_WALK: begin
                if (i_sts.out_free) begin
                    o_cmd.exec_walk = 1'b1;
                    if (i_sts.is_last) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.emitted || i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/mtbc_dp.sv
// Datapath of the blink controller: configuration, target table, walk index
// and result register. Depends on mtbc_pkg; commanded by mtbc_ctl.
`timescale 1ns / 1ps

module mtbc_dp import mtbc_pkg::*; #(
    parameter int TARGETS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_req_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_ctl_cmd              i_cmd,
    output t_ctl_sts              o_sts,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_out_item             o_rsp_data
);

    localparam int IW = (TARGETS > 1) ? $clog2(TARGETS) : 1;

    // Configuration registers.
    logic       r_cursor_en;
    logic       r_text_en;
    logic [7:0] r_cursor_blinks;
    logic [7:0] r_text_blinks;
    logic [7:0] r_skip_blinks;

    // Control state.
    logic               r_phase;
    logic               r_running;
    logic               r_any;
    logic               r_emitted;
    logic [TARGETS-1:0] r_valid;
    logic [TARGETS-1:0] r_fw;      // entry flags written since reset or the last remove
    logic [IW-1:0]      r_addr;
    t_in_item           r_item;

    // Table memory with registered read.
    t_entry r_mem [TARGETS];
    t_entry r_rd;

    logic      r_out_valid;
    t_out_item r_out;

    logic          w_in_range;
    logic [IW-1:0] w_in_addr;
    logic [IW-1:0] w_rd_addr;
    logic          w_out_free;
    logic          w_load;
    logic [TARGETS-1:0] w_ge;
    logic [TARGETS-1:0] w_gt;

    logic [CNT_W-1:0] w_cs, w_cc, w_ct;
    logic [2:0]       w_fl;
    logic             w_done;
    t_entry           w_walk;
    t_entry           w_upd;
    logic             w_upd_start;

    assign w_in_range = int'(i_req_data.target) < TARGETS;
    assign w_in_addr  = IW'(i_req_data.target);
    assign w_rd_addr  = i_cmd.rd_in ? w_in_addr : r_addr;
    assign w_out_free = !r_out_valid || i_rsp_ready;
    assign w_load     = i_cmd.exec_upd || i_cmd.exec_walk || (i_cmd.finish && !r_emitted);

    always_comb begin
        w_ge = '0;
        w_gt = '0;
        for (int j = 0; j < TARGETS; j++) begin
            w_ge[j] = r_valid[j] && (j >= int'(r_addr));
            w_gt[j] = r_valid[j] && (j > int'(r_addr));
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.in_tick    = (i_req_data.op == OP_TICK);
        o_sts.in_upd     = (i_req_data.op inside {OP_SET, OP_INPUT}) && w_in_range;
        o_sts.running    = r_running;
        o_sts.idx_valid  = r_valid[r_addr];
        o_sts.rest_empty = ~|w_ge;
        o_sts.is_last    = ~|w_gt;
        o_sts.emitted    = r_emitted;
        o_sts.out_free   = w_out_free;
    end

    // An entry that is not valid has cleared counters; flags never written read as zero.
    assign w_cs   = r_valid[r_addr] ? r_rd.skip_left   : '0;
    assign w_cc   = r_valid[r_addr] ? r_rd.cursor_left : '0;
    assign w_ct   = r_valid[r_addr] ? r_rd.text_left   : '0;
    assign w_fl   = r_fw[r_addr]    ? r_rd.flags       : '0;
    assign w_done = (w_cs == '0) && (w_cc == '0) && (w_ct == '0);

    // One tick step on the current entry.
    always_comb begin
        w_walk.skip_left   = w_cs;
        w_walk.cursor_left = w_cc;
        w_walk.text_left   = w_ct;
        w_walk.flags       = w_fl;
        if (w_done) begin
            w_walk.flags[FL_UPDATE] = 1'b0;
        end else begin
            if (w_cs != '0) begin
                w_walk.skip_left         = w_cs - CNT_W'(1);
                w_walk.flags[FL_CURSOR]  = 1'b0;
            end else if (w_cc != '0) begin
                w_walk.cursor_left       = w_cc - CNT_W'(1);
                w_walk.flags[FL_CURSOR]  = (w_cc != CNT_W'(1)) && r_cursor_en && r_phase;
            end
            if (w_ct != '0) begin
                w_walk.text_left         = w_ct - CNT_W'(1);
                w_walk.flags[FL_TEXT]    = (w_ct != CNT_W'(1)) && r_text_en && r_phase;
            end
        end
    end

    // Set-effect and input-received update of the addressed entry.
    always_comb begin
        logic flag;
        logic text_ok;
        flag        = 1'b0;
        text_ok     = 1'b0;
        w_upd.skip_left   = w_cs;
        w_upd.cursor_left = w_cc;
        w_upd.text_left   = w_ct;
        w_upd.flags       = w_fl;
        if (r_item.op == OP_INPUT) begin
            w_upd.skip_left        = {r_skip_blinks, 1'b0};
            w_upd.flags[FL_CURSOR] = 1'b0;
        end else begin
            if (r_item.is_viewport) begin
                if (r_cursor_en && r_item.is_primary) begin
                    w_upd.cursor_left = {r_cursor_blinks, 1'b0};
                    flag              = 1'b1;
                end else begin
                    w_upd.cursor_left      = '0;
                    w_upd.skip_left        = '0;
                    w_upd.flags[FL_CURSOR] = 1'b0;
                end
                text_ok = r_text_en && r_item.is_focused && r_item.blink_seen;
            end else begin
                text_ok = r_text_en && r_item.is_active;
            end
            if (text_ok) begin
                w_upd.text_left = {r_text_blinks, 1'b0};
                flag            = 1'b1;
            end else begin
                w_upd.text_left      = '0;
                w_upd.flags[FL_TEXT] = 1'b0;
            end
            w_upd.flags[FL_UPDATE] = flag;
        end
        w_upd_start = (r_item.op == OP_SET) && flag;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_upd) begin
            r_mem[r_addr] <= w_upd;
        end else if (i_cmd.exec_walk) begin
            r_mem[r_addr] <= w_walk;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_en     <= 1'b1;
            r_text_en       <= 1'b1;
            r_cursor_blinks <= 8'd10;
            r_text_blinks   <= 8'd10;
            r_skip_blinks   <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CURSOR_EN:     r_cursor_en     <= i_cfg_data[0];
                CFG_TEXT_EN:       r_text_en       <= i_cfg_data[0];
                CFG_CURSOR_BLINKS: r_cursor_blinks <= i_cfg_data;
                CFG_TEXT_BLINKS:   r_text_blinks   <= i_cfg_data;
                CFG_SKIP_BLINKS:   r_skip_blinks   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_req_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_running   <= 1'b0;
            r_any       <= 1'b0;
            r_emitted   <= 1'b0;
            r_valid     <= '0;
            r_fw        <= '0;
            r_addr      <= '0;
        end else begin
            if (i_cmd.capture) begin
                if (i_req_data.op == OP_TICK) begin
                    r_any     <= 1'b0;
                    r_emitted <= 1'b0;
                    r_addr    <= '0;
                    if (r_running) begin
                        r_phase <= ~r_phase;
                    end
                end else begin
                    r_addr <= w_in_addr;
                    if ((i_req_data.op == OP_REMOVE) && w_in_range) begin
                        r_valid[w_in_addr] <= 1'b0;
                        r_fw[w_in_addr]    <= 1'b0;
                    end
                end
            end
            if (i_cmd.exec_upd) begin
                r_valid[r_addr] <= 1'b1;
                r_fw[r_addr]    <= 1'b1;
                if (w_upd_start) begin
                    r_running <= 1'b1;
                end
            end
            if (i_cmd.exec_walk) begin
                r_emitted <= 1'b1;
                if (w_done) begin
                    r_valid[r_addr] <= 1'b0;
                end else begin
                    r_any <= 1'b1;
                end
            end
            if (i_cmd.scan_step) begin
                r_addr <= r_addr + IW'(1);
            end
            if (i_cmd.finish && !r_any) begin
                r_running <= 1'b0;
                r_phase   <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_upd) begin
            r_out.out_target   <= r_item.target;
            r_out.target_valid <= 1'b1;
            r_out.cursor_on    <= w_upd.flags[FL_CURSOR];
            r_out.text_on      <= w_upd.flags[FL_TEXT];
            r_out.update_on    <= w_upd.flags[FL_UPDATE];
            r_out.last         <= 1'b1;
        end else if (i_cmd.exec_walk) begin
            r_out.out_target   <= TGT_W'(r_addr);
            r_out.target_valid <= 1'b1;
            r_out.cursor_on    <= w_walk.flags[FL_CURSOR];
            r_out.text_on      <= w_walk.flags[FL_TEXT];
            r_out.update_on    <= w_walk.flags[FL_UPDATE];
            r_out.last         <= o_sts.is_last;
        end else if (w_load) begin
            r_out <= '{out_target: '0, target_valid: 1'b0, cursor_on: 1'b0,
                       text_on: 1'b0, update_on: 1'b0, last: 1'b1};
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_out;

`ifndef SYNTH
    a_stopped_phase_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> !r_phase)
        else $error("Blink phase is high while the timer is stopped.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("Result register loaded while a result is still pending.");

    a_valid_has_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid & ~r_fw) == '0)
        else $error("A valid entry has flags that were never written.");
`endif

endmodule

FILE: hdl/multi_target_blink_controller_unit.sv
// Top level of the multi-target blink controller.
// Depends on mtbc_pkg, mtbc_in_if, mtbc_out_if, mtbc_ctl and mtbc_dp.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake        | Payload
// ---------+-----------+------------------+------------------------------------------
// i_req    | in        | valid / ready    | op, target, viewport and file item flags
// o_rsp    | out       | valid / ready    | out_target, target_valid, flags, last
// i_cfg_*  | in        | write enable     | register index, 8-bit write data
//
// A set-effect or input-received item waits in S_UPD until the result register is
// free; a remove or an out-of-range item is absorbed in the transfer cycle.
// A tick scans the table one index per cycle over entries that are not valid; a valid
// entry moves it from S_SCAN to S_WALK, where it waits for a free result register. The
// scan ends after the last valid entry; a tick with the timer stopped goes to S_FIN.
// Reset (synchronous, active low) clears the timer, phase and valid bits at once.
// A stalled result only holds the controller when the next result is due.

module multi_target_blink_controller_unit import mtbc_pkg::*; #(
    parameter int TARGETS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mtbc_in_if.sink               i_req,
    mtbc_out_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Commands flow from the state machine to the datapath, status flows back.
    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;
    logic     w_req_ready;

    assign i_req.ready = w_req_ready;

    mtbc_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath owns the table memory, configuration and the result register,
    // so a finished result waits there while the next item is taken in.
    mtbc_dp #(
        .TARGETS (TARGETS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_req.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_data  (o_rsp.data)
    );

endmodule
